// ===== rtl/lkl_pkg.sv =====
// Shared types, codes and lookup functions for the two-wire LED/key link master.
// No dependencies; used by lkl_cfg and led_key_two_wire_link_master_unit.
package lkl_pkg;

    typedef struct packed {
        logic [1:0] op;
        logic [2:0] digit_address;
        logic [7:0] segment_value;
        logic [2:0] brightness_level;
        logic       dio_in;
    } lkl_in_t;

    typedef struct packed {
        logic       clk_out;
        logic       dio_out;
        logic       dio_drive;
        logic       busy_res;
        logic       accepted;
        logic       ack_error;
        logic       key_valid;
        logic [7:0] scan_code;
        logic [4:0] key_number;
    } lkl_out_t;

    typedef struct packed {
        logic [7:0] bit_half_ticks;
        logic [7:0] read_half_ticks;
        logic       ack_wait_enable;
        logic [7:0] ack_timeout_ticks;
    } lkl_cfg_t;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_BIT_HALF  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_READ_HALF = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ACK_WAIT  = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ACK_TMO   = 8'd3;

    localparam logic [7:0] RST_BIT_HALF  = 8'd3;
    localparam logic [7:0] RST_READ_HALF = 8'd30;
    localparam logic       RST_ACK_WAIT  = 1'b1;
    localparam logic [7:0] RST_ACK_TMO   = 8'd100;

    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_DIGIT  = 2'd1;
    localparam logic [1:0] OP_BRIGHT = 2'd2;
    localparam logic [1:0] OP_SCAN   = 2'd3;

    localparam logic [3:0] K_END    = 4'd0;
    localparam logic [3:0] K_START  = 4'd1;
    localparam logic [3:0] K_ACK    = 4'd2;
    localparam logic [3:0] K_STOP   = 4'd3;
    localparam logic [3:0] K_READ   = 4'd4;
    localparam logic [3:0] K_B44    = 4'd5;
    localparam logic [3:0] K_BADDR  = 4'd6;
    localparam logic [3:0] K_BVAL   = 4'd7;
    localparam logic [3:0] K_BLEVEL = 4'd8;
    localparam logic [3:0] K_B42    = 4'd9;

    localparam logic [7:0] BYTE_MODE_FIXED = 8'h44;
    localparam logic [7:0] BYTE_ADDR_BASE  = 8'hC0;
    localparam logic [7:0] BYTE_DISP_ON    = 8'h88;
    localparam logic [7:0] BYTE_READ_KEYS  = 8'h42;

    function automatic logic [3:0] kind_of(input logic [1:0] cmd, input logic [4:0] step);
        logic [3:0] k;
        k = K_END;
        unique case (cmd)
            OP_DIGIT: begin
                unique case (step)
                    5'd1:    k = K_START;
                    5'd2:    k = K_B44;
                    5'd3:    k = K_ACK;
                    5'd4:    k = K_STOP;
                    5'd5:    k = K_START;
                    5'd6:    k = K_BADDR;
                    5'd7:    k = K_ACK;
                    5'd8:    k = K_BVAL;
                    5'd9:    k = K_ACK;
                    5'd10:   k = K_STOP;
                    default: k = K_END;
                endcase
            end
            OP_BRIGHT: begin
                unique case (step)
                    5'd1:    k = K_START;
                    5'd2:    k = K_BLEVEL;
                    5'd3:    k = K_ACK;
                    5'd4:    k = K_STOP;
                    default: k = K_END;
                endcase
            end
            OP_SCAN: begin
                unique case (step)
                    5'd1:    k = K_START;
                    5'd2:    k = K_B42;
                    5'd3:    k = K_ACK;
                    5'd4:    k = K_READ;
                    5'd5:    k = K_ACK;
                    5'd6:    k = K_STOP;
                    default: k = K_END;
                endcase
            end
            default: k = K_END;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] halves_of(input logic [3:0] k);
        logic [4:0] h;
        h = 5'd16;
        if (k == K_START) begin
            h = 5'd2;
        end else if (k == K_ACK || k == K_STOP) begin
            h = 5'd3;
        end
        return h;
    endfunction

    function automatic logic [4:0] decode_key(input logic [7:0] c);
        logic [4:0] n;
        n = 5'd0;
        if (c[7:3] == 5'b11110) begin
            n = 5'd8 - {2'b00, c[2:0]};
        end else if (c[7:3] == 5'b11101) begin
            n = 5'd16 - {2'b00, c[2:0]};
        end
        return n;
    endfunction

endpackage

// ===== rtl/lkl_cfg.sv =====
// Configuration register file for the two-wire link master.
// Depends on lkl_pkg for the register indexes, reset values and lkl_cfg_t.
module lkl_cfg
    import lkl_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [CFG_DATA_W-1:0]  wr_data,
    output lkl_cfg_t               cfg
);

    lkl_cfg_t cfg_reg;
    lkl_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (wr_index)
                REG_BIT_HALF:  cfg_next.bit_half_ticks    = wr_data;
                REG_READ_HALF: cfg_next.read_half_ticks   = wr_data;
                REG_ACK_WAIT:  cfg_next.ack_wait_enable   = wr_data[0];
                REG_ACK_TMO:   cfg_next.ack_timeout_ticks = wr_data;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.bit_half_ticks    <= RST_BIT_HALF;
            cfg_reg.read_half_ticks   <= RST_READ_HALF;
            cfg_reg.ack_wait_enable   <= RST_ACK_WAIT;
            cfg_reg.ack_timeout_ticks <= RST_ACK_TMO;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/led_key_two_wire_link_master_unit.sv =====
// Two-wire LED/key link master: pin sequencer and result register.
// Depends on lkl_pkg and lkl_cfg.
//
// Every input word (a tick or a command) yields exactly one result word with the
// clock/data line levels and status after that word. One word is taken per clock
// cycle; its result appears in the output register on the next cycle. The output
// register lets a new word in while the last result is still being taken, so the
// only stall is m_ready held low with a result pending. Line timing is counted in
// input words (ticks), not clock cycles. Configuration writes are always ready.
module led_key_two_wire_link_master_unit
    import lkl_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  lkl_in_t                s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output lkl_out_t               m_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    lkl_cfg_t cfg;

    logic [4:0] step_reg,  step_next;
    logic [3:0] bc_reg,    bc_next;
    logic [7:0] shift_reg, shift_next;
    logic [7:0] tick_reg,  tick_next;
    logic [1:0] cmd_reg,   cmd_next;
    logic [2:0] addr_reg,  addr_next;
    logic [7:0] val_reg,   val_next;
    logic [2:0] lvl_reg,   lvl_next;
    logic [7:0] rd_reg,    rd_next;
    logic       err_reg,   err_next;
    logic       m_valid_reg;
    lkl_out_t   out_reg;
    lkl_out_t   result;

    logic       s_fire;
    logic [3:0] k_cur;
    logic [3:0] k_new;
    logic [3:0] k_out;
    logic [4:0] target;
    logic [7:0] tick_inc;
    logic [7:0] half_len;
    logic [7:0] tmo;
    logic [3:0] bc_inc;
    logic       end_h;
    logic       enter;
    logic       acc;
    logic       kv;

    lkl_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign s_fire    = s_valid && s_ready;

    always_comb begin
        step_next  = step_reg;
        bc_next    = bc_reg;
        shift_next = shift_reg;
        tick_next  = tick_reg;
        cmd_next   = cmd_reg;
        addr_next  = addr_reg;
        val_next   = val_reg;
        lvl_next   = lvl_reg;
        rd_next    = rd_reg;
        err_next   = err_reg;
        acc        = 1'b0;
        kv         = 1'b0;
        end_h      = 1'b0;
        enter      = 1'b0;
        bc_inc     = bc_reg;
        k_cur      = kind_of(cmd_reg, step_reg);
        tick_inc   = tick_reg + 8'd1;
        half_len   = (k_cur == K_READ) ? cfg.read_half_ticks : cfg.bit_half_ticks;
        if (half_len == 8'd0) begin
            half_len = 8'd1;
        end
        tmo = (cfg.ack_timeout_ticks == 8'd0) ? 8'd1 : cfg.ack_timeout_ticks;

        if (step_reg == 5'd0) begin
            if (s_data.op != OP_TICK) begin
                acc       = 1'b1;
                err_next  = 1'b0;
                cmd_next  = s_data.op;
                addr_next = s_data.digit_address;
                val_next  = s_data.segment_value;
                lvl_next  = s_data.brightness_level;
                enter     = 1'b1;
            end
        end else if (k_cur == K_END) begin
            step_next = 5'd0;
        end else if (k_cur == K_ACK && bc_reg == 4'd1) begin
            if (!s_data.dio_in) begin
                end_h = 1'b1;
            end else begin
                tick_next = tick_inc;
                if (tick_inc >= tmo) begin
                    err_next = 1'b1;
                    end_h    = 1'b1;
                end
            end
        end else begin
            tick_next = tick_inc;
            if (tick_inc >= half_len) begin
                if (bc_reg[0] && k_cur >= K_B44) begin
                    shift_next = {1'b0, shift_reg[7:1]};
                end
                if (bc_reg[0] && k_cur == K_READ) begin
                    rd_next = {s_data.dio_in, rd_reg[7:1]};
                end
                end_h = 1'b1;
            end
        end

        if (end_h) begin
            tick_next = 8'd0;
            bc_inc    = bc_reg + 4'd1;
            if (k_cur == K_ACK && bc_inc == 4'd1 && !cfg.ack_wait_enable) begin
                bc_inc = 4'd2;
            end
            bc_next = bc_inc;
            if ({1'b0, bc_inc} >= halves_of(k_cur) || bc_inc == 4'd0) begin
                enter = 1'b1;
            end
        end

        target = acc ? 5'd1 : step_reg + 5'd1;
        k_new  = kind_of(cmd_next, target);
        if (enter) begin
            step_next = target;
            bc_next   = 4'd0;
            tick_next = 8'd0;
            unique case (k_new)
                K_END: begin
                    step_next = 5'd0;
                    kv        = (cmd_next == OP_SCAN);
                end
                K_B44:    shift_next = BYTE_MODE_FIXED;
                K_BADDR:  shift_next = BYTE_ADDR_BASE | {5'd0, addr_next};
                K_BVAL:   shift_next = val_next;
                K_BLEVEL: shift_next = BYTE_DISP_ON | {5'd0, lvl_next};
                K_B42:    shift_next = BYTE_READ_KEYS;
                default:  shift_next = shift_next;
            endcase
        end

        k_out            = kind_of(cmd_next, step_next);
        result.clk_out   = 1'b1;
        result.dio_out   = 1'b1;
        result.dio_drive = 1'b1;
        priority if (k_out == K_START) begin
            result.dio_out = (bc_next == 4'd0);
        end else if (k_out == K_ACK) begin
            result.clk_out   = (bc_next == 4'd2);
            result.dio_out   = 1'b0;
            result.dio_drive = 1'b0;
        end else if (k_out == K_STOP) begin
            result.clk_out = (bc_next != 4'd0);
            result.dio_out = (bc_next == 4'd2);
        end else if (k_out == K_READ) begin
            result.clk_out   = bc_next[0];
            result.dio_out   = 1'b0;
            result.dio_drive = 1'b0;
        end else if (k_out >= K_B44) begin
            result.clk_out = bc_next[0];
            result.dio_out = shift_next[0];
        end else begin
            result.clk_out = 1'b1;
        end
        result.busy_res   = (step_next != 5'd0);
        result.accepted   = acc;
        result.ack_error  = err_next;
        result.key_valid  = kv;
        result.scan_code  = rd_next;
        result.key_number = decode_key(rd_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= 5'd0;
            bc_reg      <= 4'd0;
            shift_reg   <= 8'd0;
            tick_reg    <= 8'd0;
            cmd_reg     <= OP_TICK;
            addr_reg    <= 3'd0;
            val_reg     <= 8'd0;
            lvl_reg     <= 3'd0;
            rd_reg      <= 8'd0;
            err_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                step_reg    <= step_next;
                bc_reg      <= bc_next;
                shift_reg   <= shift_next;
                tick_reg    <= tick_next;
                cmd_reg     <= cmd_next;
                addr_reg    <= addr_next;
                val_reg     <= val_next;
                lvl_reg     <= lvl_next;
                rd_reg      <= rd_next;
                err_reg     <= err_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            out_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

// ===== sim/lkl_link_board_pkg.sv =====
// Scoreboard for the two-wire LED/key link master: a pin sequencer predictor that
// queues the expected line levels per input word and checks result words in order.
// Depends on lkl_pkg for the word types, op codes, element kinds and register indexes.
package lkl_link_board_pkg;
    import lkl_pkg::*;

    localparam logic [7:0] KEY_ROW0_TOP = 8'hF7;
    localparam logic [7:0] KEY_ROW0_LOW = 8'hF0;
    localparam logic [7:0] KEY_ROW1_TOP = 8'hEF;
    localparam logic [7:0] KEY_ROW1_LOW = 8'hE8;

    class link_line_board;
        logic [7:0] write_half;
        logic [7:0] read_half;
        logic       ack_wait;
        logic [7:0] ack_limit;
        logic [4:0] step;
        logic [3:0] half;
        logic [7:0] shifter;
        logic [7:0] ticks;
        logic [1:0] cmd;
        logic [2:0] addr;
        logic [7:0] segs;
        logic [2:0] level;
        logic [7:0] key_byte;
        logic       ack_lost;
        logic       scan_done;
        lkl_out_t   line_levels [$];
        int         mismatches;

        function new();
            write_half = RST_BIT_HALF;
            read_half  = RST_READ_HALF;
            ack_wait   = RST_ACK_WAIT;
            ack_limit  = RST_ACK_TMO;
            step       = '0;
            half       = '0;
            shifter    = '0;
            ticks      = '0;
            cmd        = OP_TICK;
            addr       = '0;
            segs       = '0;
            level      = '0;
            key_byte   = '0;
            ack_lost   = 1'b0;
            scan_done  = 1'b0;
            mismatches = 0;
        endfunction

        function void set_reg(input logic [CFG_INDEX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_BIT_HALF:  write_half = val;
                REG_READ_HALF: read_half  = val;
                REG_ACK_WAIT:  ack_wait   = val[0];
                REG_ACK_TMO:   ack_limit  = val;
                default: ;
            endcase
        endfunction

        function logic [3:0] element_at();
            logic [3:0] seq [10];
            case (cmd)
                OP_DIGIT:  seq = '{K_START, K_B44, K_ACK, K_STOP, K_START,
                                   K_BADDR, K_ACK, K_BVAL, K_ACK, K_STOP};
                OP_BRIGHT: seq = '{K_START, K_BLEVEL, K_ACK, K_STOP, K_END,
                                   K_END, K_END, K_END, K_END, K_END};
                OP_SCAN:   seq = '{K_START, K_B42, K_ACK, K_READ, K_ACK,
                                   K_STOP, K_END, K_END, K_END, K_END};
                default:   seq = '{default: K_END};
            endcase
            if (step == 0 || step > 10) return K_END;
            return seq[step - 1];
        endfunction

        function logic [4:0] halves(input logic [3:0] k);
            if (k == K_START) return 5'd2;
            if (k == K_ACK || k == K_STOP) return 5'd3;
            return 5'd16;
        endfunction

        function logic [7:0] floor1(input logic [7:0] v);
            return (v == 0) ? 8'd1 : v;
        endfunction

        function logic [4:0] key_of(input logic [7:0] c);
            if (c >= KEY_ROW0_LOW && c <= KEY_ROW0_TOP) return 5'(KEY_ROW0_TOP - c + 1);
            if (c >= KEY_ROW1_LOW && c <= KEY_ROW1_TOP) return 5'(KEY_ROW1_TOP - c + 9);
            return 5'd0;
        endfunction

        function void enter(input logic [4:0] nstep);
            logic [3:0] k;
            step  = nstep;
            half  = '0;
            ticks = '0;
            k = element_at();
            if (k == K_END) begin
                if (cmd == OP_SCAN) scan_done = 1'b1;
                step = '0;
                return;
            end
            case (k)
                K_B44:    shifter = BYTE_MODE_FIXED;
                K_BADDR:  shifter = BYTE_ADDR_BASE | {5'd0, addr};
                K_BVAL:   shifter = segs;
                K_BLEVEL: shifter = BYTE_DISP_ON | {5'd0, level};
                K_B42:    shifter = BYTE_READ_KEYS;
                default: ;
            endcase
        endfunction

        function void close_half(input logic [3:0] k);
            ticks = '0;
            half  = half + 4'd1;
            if (k == K_ACK && half == 1 && !ack_wait) half = 4'd2;
            if ({1'b0, half} >= halves(k) || half == 0) enter(step + 5'd1);
        endfunction

        function void advance(input logic dio);
            logic [3:0] k;
            logic [7:0] len;
            k = element_at();
            if (k == K_END) begin
                step = '0;
                return;
            end
            if (k == K_ACK && half == 1) begin
                if (!dio) begin
                    close_half(k);
                    return;
                end
                ticks = ticks + 8'd1;
                if (ticks >= floor1(ack_limit)) begin
                    ack_lost = 1'b1;
                    close_half(k);
                end
                return;
            end
            len   = floor1(k == K_READ ? read_half : write_half);
            ticks = ticks + 8'd1;
            if (ticks < len) return;
            if (half[0] && k >= K_B44) shifter = shifter >> 1;
            if (half[0] && k == K_READ) key_byte = {dio, key_byte[7:1]};
            close_half(k);
        endfunction

        function void note_word(input lkl_in_t w);
            lkl_out_t   e;
            logic [3:0] k;
            e = '0;
            scan_done = 1'b0;
            if (step == 0) begin
                if (w.op != OP_TICK) begin
                    e.accepted = 1'b1;
                    ack_lost   = 1'b0;
                    cmd        = w.op;
                    addr       = w.digit_address;
                    segs       = w.segment_value;
                    level      = w.brightness_level;
                    enter(5'd1);
                end
            end else begin
                advance(w.dio_in);
            end
            k = element_at();
            case (k)
                K_END: begin
                    e.clk_out = 1'b1; e.dio_out = 1'b1; e.dio_drive = 1'b1;
                end
                K_START: begin
                    e.clk_out = 1'b1; e.dio_out = (half == 0); e.dio_drive = 1'b1;
                end
                K_ACK: begin
                    e.clk_out = (half == 2); e.dio_out = 1'b0; e.dio_drive = 1'b0;
                end
                K_STOP: begin
                    e.clk_out = (half != 0); e.dio_out = (half == 2); e.dio_drive = 1'b1;
                end
                K_READ: begin
                    e.clk_out = half[0]; e.dio_out = 1'b0; e.dio_drive = 1'b0;
                end
                default: begin
                    e.clk_out = half[0]; e.dio_out = shifter[0]; e.dio_drive = 1'b1;
                end
            endcase
            e.busy_res   = (step != 0);
            e.ack_error  = ack_lost;
            e.key_valid  = scan_done;
            e.scan_code  = key_byte;
            e.key_number = key_of(key_byte);
            line_levels.push_back(e);
        endfunction

        function void check_word(input lkl_out_t got);
            lkl_out_t e;
            string    bad;
            if (line_levels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %p", got);
                return;
            end
            e = line_levels.pop_front();
            bad = "";
            if (got.clk_out !== e.clk_out)       bad = {bad, " clk_out"};
            if (got.dio_out !== e.dio_out)       bad = {bad, " dio_out"};
            if (got.dio_drive !== e.dio_drive)   bad = {bad, " dio_drive"};
            if (got.busy_res !== e.busy_res)     bad = {bad, " busy_res"};
            if (got.accepted !== e.accepted)     bad = {bad, " accepted"};
            if (got.ack_error !== e.ack_error)   bad = {bad, " ack_error"};
            if (got.key_valid !== e.key_valid)   bad = {bad, " key_valid"};
            if (got.scan_code !== e.scan_code)   bad = {bad, " scan_code"};
            if (got.key_number !== e.key_number) bad = {bad, " key_number"};
            if (bad != "") begin
                mismatches++;
                if (mismatches <= 10) $display("mismatch in%s: expected %p got %p", bad, e, got);
            end
        endfunction

        function int pending();
            return line_levels.size();
        endfunction

        function void close_out();
            if (line_levels.size() != 0) begin
                $display("%0d result words never arrived", line_levels.size());
                mismatches += line_levels.size();
            end
        endfunction
    endclass

endpackage

// ===== sim/tb.sv =====
// Top-level testbench for led_key_two_wire_link_master_unit: drives tick and command
// words with random gaps and stalls, writes timing registers between phases.
// Depends on lkl_pkg and lkl_link_board_pkg.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lkl_pkg::*;
    import lkl_link_board_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int STALL_CYCLES = 300;

    typedef enum logic [1:0] {ACK_PROMPT, ACK_LATE, ACK_NEVER} ack_style_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    lkl_in_t                s_data;
    logic                   m_valid;
    logic                   m_ready;
    lkl_out_t               m_data;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    link_line_board board = new();
    int             send_idle_pct;
    int             recv_idle_pct;
    int             words_sent;
    int             cycle_count;
    bit             stall_req;
    logic [7:0]     scan_target;
    ack_style_t     ack_style;

    led_key_two_wire_link_master_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int hold_left;
        bit stall_done;
        hold_left  = 0;
        stall_done = 1'b0;
        m_ready    = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_ready = 1'b0;
                hold_left--;
            end else if (stall_req && !stall_done) begin
                stall_done = 1'b1;
                hold_left  = STALL_CYCLES - 1;
                m_ready    = 1'b0;
            end else begin
                m_ready = ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_word(m_data);
    end

    function automatic logic next_dio();
        logic [3:0] k;
        k = board.element_at();
        if (k == K_READ) return scan_target[board.half[3:1]];
        if (k == K_ACK && board.half == 1) begin
            case (ack_style)
                ACK_PROMPT: return 1'b0;
                ACK_NEVER:  return 1'b1;
                default:    return ($urandom_range(3) != 0);
            endcase
        end
        return 1'($urandom_range(1));
    endfunction

    task automatic send_word(input lkl_in_t w);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_data  = w;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        board.note_word(w);
        words_sent++;
        @(negedge aclk);
    endtask

    task automatic send_tick(input int noise_pct);
        lkl_in_t w;
        w.op = OP_TICK;
        if ($urandom_range(99) < noise_pct) w.op = 2'($urandom_range(OP_DIGIT, OP_SCAN));
        w.digit_address    = 3'($urandom);
        w.segment_value    = 8'($urandom);
        w.brightness_level = 3'($urandom);
        w.dio_in           = next_dio();
        send_word(w);
    endtask

    task automatic run_command(input logic [1:0] op, input logic [2:0] adr,
                               input logic [7:0] val, input logic [2:0] lvl,
                               input logic [7:0] target, input ack_style_t style,
                               input int noise_pct);
        lkl_in_t w;
        scan_target        = target;
        ack_style          = style;
        w.op               = op;
        w.digit_address    = adr;
        w.segment_value    = val;
        w.brightness_level = lvl;
        w.dio_in           = 1'($urandom_range(1));
        send_word(w);
        while (board.step != 0) send_tick(noise_pct);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_index = idx;
        cfg_data  = val;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        board.set_reg(idx, val);
        @(negedge aclk);
    endtask

    task automatic set_timing(input logic [7:0] bit_half, input logic [7:0] rd_half,
                              input logic wait_ack, input logic [7:0] tmo);
        s_valid = 1'b0;
        while (board.pending() != 0) @(negedge aclk);
        write_reg(REG_BIT_HALF, bit_half);
        write_reg(REG_READ_HALF, rd_half);
        write_reg(REG_ACK_WAIT, {7'd0, wait_ack});
        write_reg(REG_ACK_TMO, tmo);
        cfg_valid = 1'b0;
    endtask

    task automatic random_command();
        logic [7:0] target;
        ack_style_t style;
        int         pick;
        int         n;
        pick  = $urandom_range(99);
        style = (pick < 60) ? ACK_PROMPT : (pick < 85) ? ACK_LATE : ACK_NEVER;
        n     = $urandom_range(15);
        if ($urandom_range(9) < 6) begin
            target = (n < 8) ? KEY_ROW0_LOW + 8'(n) : KEY_ROW1_LOW + 8'(n - 8);
        end else begin
            target = 8'($urandom);
        end
        if ($urandom_range(9) == 0) send_tick(0);
        run_command(2'($urandom_range(OP_DIGIT, OP_SCAN)), 3'($urandom), 8'($urandom),
                    3'($urandom), target, style, 8);
    endtask

    initial begin
        int phase_start;
        int drain;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        send_idle_pct = 34;
        recv_idle_pct = 34;
        words_sent    = 0;
        stall_req     = 1'b0;
        scan_target   = '0;
        ack_style     = ACK_PROMPT;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset timing
        send_tick(0);
        run_command(OP_BRIGHT, 3'd0, 8'h00, 3'd5, 8'h00, ACK_PROMPT, 0);
        run_command(OP_SCAN, 3'd0, 8'h00, 3'd0, 8'hF5, ACK_LATE, 0);

        // fastest timing, every key edge, busy commands, ack timeout
        set_timing(8'd1, 8'd1, 1'b1, 8'd1);
        run_command(OP_DIGIT, 3'd0, 8'h00, 3'd0, 8'h00, ACK_PROMPT, 0);
        run_command(OP_DIGIT, 3'd7, 8'h80, 3'd2, 8'h00, ACK_PROMPT, 0);
        run_command(OP_BRIGHT, 3'd7, 8'hFF, 3'd7, 8'h00, ACK_PROMPT, 100);
        run_command(OP_SCAN, 3'd0, 8'h00, 3'd0, KEY_ROW0_TOP, ACK_PROMPT, 0);
        run_command(OP_SCAN, 3'd0, 8'h00, 3'd0, KEY_ROW0_LOW, ACK_PROMPT, 0);
        run_command(OP_SCAN, 3'd0, 8'h00, 3'd0, KEY_ROW1_TOP, ACK_PROMPT, 0);
        run_command(OP_SCAN, 3'd0, 8'h00, 3'd0, KEY_ROW1_LOW, ACK_PROMPT, 0);
        run_command(OP_SCAN, 3'd0, 8'h00, 3'd0, 8'hFF, ACK_NEVER, 0);

        // zero registers count as one tick, ack check off
        set_timing(8'd0, 8'd0, 1'b0, 8'd0);
        run_command(OP_DIGIT, 3'd3, 8'h5A, 3'd0, 8'h00, ACK_NEVER, 0);
        run_command(OP_BRIGHT, 3'd0, 8'h00, 3'd4, 8'h00, ACK_NEVER, 0);
        run_command(OP_SCAN, 3'd0, 8'h00, 3'd0, 8'hEC, ACK_NEVER, 0);

        for (int ph = 0; ph < 4; ph++) begin
            set_timing(8'($urandom_range(3)), 8'($urandom_range(1, 4)),
                       1'($urandom_range(1)), 8'($urandom_range(1, 12)));
            @(posedge aclk);
            send_idle_pct = (ph == 1) ? 0 : 34;
            recv_idle_pct = send_idle_pct;
            stall_req     = (ph == 2);
            @(negedge aclk);
            phase_start = words_sent;
            while (words_sent - phase_start < 40) random_command();
        end

        s_valid = 1'b0;
        drain   = 0;
        while (board.pending() != 0 && drain < 10000) begin
            @(posedge aclk);
            drain++;
        end
        repeat (5) @(posedge aclk);
        board.close_out();
        if (board.mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
